>>> design/pqsd_pkg.sv
// pqsd_pkg: shared types and constants for the PQ symmetric-distance top-K scan.
// No dependencies; used by every other file of the block.
package pqsd_pkg;

  localparam int TOP_K_DEF      = 100;
  localparam int CODEBOOK_DEF   = 256;
  localparam int SUBSPACES_DEF  = 4;

  localparam int CODE_FIELDS = 4;   // item carries four codewords
  localparam int CODE_W      = 8;
  localparam int DIST_W      = 16;
  localparam int SUM_W       = 18;
  localparam int IDX_W       = 20;
  localparam int RANK_W      = 7;
  localparam int CFG_IDX_W   = 2;

  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_PTR_W  = 2;
  localparam int FIFO_CNT_W  = 3;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_ITEM  = 2'd1,
    KIND_READ  = 2'd2,
    KIND_CLEAR = 2'd3
  } kind_t;

  // command handed from the front end to the list engine
  typedef struct packed {
    kind_t               kind;
    logic [SUM_W-1:0]    dsum;
    logic [IDX_W-1:0]    idx;
    logic [RANK_W-1:0]   rank;
  } cmd_t;

  typedef struct packed {
    logic [FIFO_CNT_W-1:0] count;
  } fifo_stat_t;

endpackage

>>> design/pqsd_in_if.sv
// pqsd_in_if: input channel (valid/ready plus item fields).
// Depends on pqsd_pkg.
interface pqsd_in_if import pqsd_pkg::*;;
  logic                valid;
  logic                ready;
  logic [1:0]          kind;
  logic [1:0]          table_sub;
  logic [CODE_W-1:0]   table_row;
  logic [CODE_W-1:0]   table_col;
  logic [DIST_W-1:0]   table_value;
  logic [IDX_W-1:0]    entry_index;
  logic [CODE_W-1:0]   code_a;
  logic [CODE_W-1:0]   code_b;
  logic [CODE_W-1:0]   code_c;
  logic [CODE_W-1:0]   code_d;
  logic [RANK_W-1:0]   read_rank;

  modport source (output valid, kind, table_sub, table_row, table_col, table_value,
                  entry_index, code_a, code_b, code_c, code_d, read_rank,
                  input ready);
  modport sink   (input valid, kind, table_sub, table_row, table_col, table_value,
                  entry_index, code_a, code_b, code_c, code_d, read_rank,
                  output ready);
endinterface

>>> design/pqsd_out_if.sv
// pqsd_out_if: result channel (valid/ready plus rank read-out fields).
// Depends on pqsd_pkg.
interface pqsd_out_if import pqsd_pkg::*;;
  logic                valid;
  logic                ready;
  logic                rank_valid;
  logic [IDX_W-1:0]    found_index;
  logic [SUM_W-1:0]    found_distance;

  modport source (output valid, rank_valid, found_index, found_distance, input ready);
  modport sink   (input valid, rank_valid, found_index, found_distance, output ready);
endinterface

>>> design/pqsd_front.sv
// pqsd_front: accepts beats, holds query registers and distance-table banks,
// sums per-subspace distances and pushes commands. Depends on pqsd_pkg, pqsd_in_if.
module pqsd_front import pqsd_pkg::*; #(
  parameter int CODEBOOK_SIZE = CODEBOOK_DEF,
  parameter int SUBSPACES     = SUBSPACES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  pqsd_in_if.sink               in_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CODE_W-1:0]     cfg_wdata,
  input  fifo_stat_t            fifo_stat,
  output logic                  push,
  output cmd_t                  push_cmd
);

  localparam int NB        = (SUBSPACES < CODE_FIELDS) ? SUBSPACES : CODE_FIELDS;
  localparam int CW        = $clog2(CODEBOOK_SIZE);
  localparam int TBL_DEPTH = 1 << (2 * CW);
  localparam logic [CODE_W:0] CB_LIM = (CODE_W + 1)'(CODEBOOK_SIZE);

  logic [CODE_W-1:0]   qry_r [CODE_FIELDS];
  logic [CODE_W-1:0]   code_in [CODE_FIELDS];
  logic                accept;
  kind_t               kind_in;
  logic [FIFO_CNT_W:0] occ;

  logic                st_v_r;
  kind_t               st_kind_r;
  logic [IDX_W-1:0]    st_idx_r;
  logic [RANK_W-1:0]   st_rank_r;
  logic [NB-1:0]       st_use_r;
  logic [NB-1:0]       use_nxt;
  logic [DIST_W-1:0]   rdata [NB];
  logic [2*CW-1:0]     rd_addr [NB];

  logic [CODE_W-1:0]   wr_hi, wr_lo;
  logic [2*CW-1:0]     wr_addr;
  logic                wr_ok;
  logic [SUM_W-1:0]    sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CODE_FIELDS; i++) qry_r[i] <= '0;
    end else if (cfg_we) begin
      qry_r[cfg_index] <= cfg_wdata;
    end
  end

  assign kind_in = kind_t'(in_ch.kind);
  assign occ     = {1'b0, fifo_stat.count} + {{FIFO_CNT_W{1'b0}}, st_v_r};
  // one staged command may still be on its way into the queue
  assign in_ch.ready = occ < (FIFO_CNT_W + 1)'(FIFO_DEPTH);
  assign accept  = in_ch.valid && in_ch.ready;

  assign code_in[0] = in_ch.code_a;
  assign code_in[1] = in_ch.code_b;
  assign code_in[2] = in_ch.code_c;
  assign code_in[3] = in_ch.code_d;

  // table is kept at (larger, smaller)
  assign wr_hi   = (in_ch.table_row > in_ch.table_col) ? in_ch.table_row : in_ch.table_col;
  assign wr_lo   = (in_ch.table_row > in_ch.table_col) ? in_ch.table_col : in_ch.table_row;
  assign wr_addr = {wr_hi[CW-1:0], wr_lo[CW-1:0]};
  assign wr_ok   = accept && (kind_in == KIND_WRITE) && ({1'b0, wr_hi} < CB_LIM);

  for (genvar b = 0; b < NB; b++) begin : g_bank
    logic [DIST_W-1:0] mem [TBL_DEPTH];
    logic [CODE_W-1:0] hi, lo;
    logic              wr_en;

    assign hi = (qry_r[b] > code_in[b]) ? qry_r[b] : code_in[b];
    assign lo = (qry_r[b] > code_in[b]) ? code_in[b] : qry_r[b];
    assign rd_addr[b] = {hi[CW-1:0], lo[CW-1:0]};
    assign use_nxt[b] = (qry_r[b] != code_in[b]) && ({1'b0, qry_r[b]} < CB_LIM)
                        && ({1'b0, code_in[b]} < CB_LIM);
    assign wr_en = wr_ok && (32'(in_ch.table_sub) == b);

    always_ff @(posedge clk) begin
      if (wr_en) mem[wr_addr] <= in_ch.table_value;
      if (accept && kind_in == KIND_ITEM) rdata[b] <= mem[rd_addr[b]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_v_r <= 1'b0;
    end else begin
      st_v_r <= accept && (kind_in != KIND_WRITE);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      st_kind_r <= kind_in;
      st_idx_r  <= in_ch.entry_index;
      st_rank_r <= in_ch.read_rank;
      st_use_r  <= use_nxt;
    end
  end

  always_comb begin
    sum = '0;
    for (int b = 0; b < NB; b++) begin
      if (st_use_r[b]) sum = sum + SUM_W'(rdata[b]);
    end
  end

  assign push          = st_v_r;
  assign push_cmd.kind = st_kind_r;
  assign push_cmd.dsum = sum;
  assign push_cmd.idx  = st_idx_r;
  assign push_cmd.rank = st_rank_r;

endmodule

>>> design/pqsd_fifo.sv
// pqsd_fifo: short command queue between front end and list engine.
// Depends on pqsd_pkg.
module pqsd_fifo import pqsd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  cmd_t       push_cmd,
  input  logic       pop,
  output logic       head_v,
  output cmd_t       head_cmd,
  output fifo_stat_t stat
);

  cmd_t                  buf_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wp_r, rp_r;
  logic [FIFO_CNT_W-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (push) buf_r[wp_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + {{(FIFO_CNT_W-1){1'b0}}, push} - {{(FIFO_CNT_W-1){1'b0}}, pop};
    end
  end

  assign head_v     = cnt_r != '0;
  assign head_cmd   = buf_r[rp_r];
  assign stat.count = cnt_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (cnt_r < FIFO_CNT_W'(FIFO_DEPTH)) || pop)
    else $error("command queue overflow");
  assert property (@(posedge clk) disable iff (!rst_n) pop |-> head_v)
    else $error("command queue underflow");
  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("command queue count out of range");

endmodule

>>> design/pqsd_back.sv
// pqsd_back: sorted top-K list in a single-port-write memory, insertion from the
// tail one entry per cycle, rank read-out through an output register. Depends on pqsd_pkg.
module pqsd_back import pqsd_pkg::*; #(
  parameter int TOP_K = TOP_K_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       head_v,
  input  cmd_t       head_cmd,
  output logic       pop,
  pqsd_out_if.source out_ch
);

  localparam int AW   = (TOP_K > 1) ? $clog2(TOP_K) : 1;
  localparam int CNTW = $clog2(TOP_K + 1);
  localparam int EW   = SUM_W + IDX_W;
  localparam logic [CNTW-1:0] K_CNT  = CNTW'(TOP_K);
  localparam logic [AW-1:0]   K_LAST = AW'(TOP_K - 1);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_FINAL  = 4'b0100,
    ST_RDWAIT = 4'b1000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNTW-1:0]  cnt_r, cnt_nxt;
  logic [AW-1:0]    slot_r, slot_nxt;
  logic [AW-1:0]    rda_r, rda_nxt;
  logic [EW-1:0]    new_r, new_nxt;
  logic             out_v_r, out_v_nxt;
  logic             out_rv_r, out_rv_nxt;
  logic [IDX_W-1:0] out_idx_r, out_idx_nxt;
  logic [SUM_W-1:0] out_dist_r, out_dist_nxt;

  logic [EW-1:0]    mem [TOP_K];
  logic [EW-1:0]    rdata_r;
  logic             we, re;
  logic [AW-1:0]    waddr, raddr;
  logic [EW-1:0]    wdata;

  logic             can_pop, full, new_lt;
  logic [CNTW-1:0]  cnt_m1;
  logic [8:0]       rank9;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_r <= mem[raddr];
  end

  assign full    = cnt_r == K_CNT;
  assign cnt_m1  = cnt_r - 1'b1;
  assign rank9   = {2'b00, head_cmd.rank};
  // (distance, index) order is plain order of the concatenation
  assign new_lt  = new_r < rdata_r;
  assign can_pop = (head_cmd.kind != KIND_READ) || !out_v_r || out_ch.ready;
  assign pop     = (state_r == ST_IDLE) && head_v && can_pop;

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    slot_nxt     = slot_r;
    rda_nxt      = rda_r;
    new_nxt      = new_r;
    out_v_nxt    = out_v_r && !out_ch.ready;
    out_rv_nxt   = out_rv_r;
    out_idx_nxt  = out_idx_r;
    out_dist_nxt = out_dist_r;
    we    = 1'b0;
    re    = 1'b0;
    waddr = slot_r;
    raddr = rda_r;
    wdata = new_r;

    case (state_r)
      ST_IDLE: begin
        if (pop) begin
          case (head_cmd.kind)
            KIND_ITEM: begin
              new_nxt = {head_cmd.dsum, head_cmd.idx};
              if (cnt_r == '0) begin
                we      = 1'b1;
                waddr   = '0;
                wdata   = {head_cmd.dsum, head_cmd.idx};
                cnt_nxt = CNTW'(1);
              end else begin
                re        = 1'b1;
                raddr     = full ? K_LAST : cnt_m1[AW-1:0];
                rda_nxt   = raddr;
                slot_nxt  = full ? K_LAST : cnt_r[AW-1:0];
                if (!full) cnt_nxt = cnt_r + 1'b1;
                state_nxt = ST_SCAN;
              end
            end
            KIND_READ: begin
              if (32'(head_cmd.rank) < 32'(cnt_r)) begin
                re        = 1'b1;
                raddr     = rank9[AW-1:0];
                state_nxt = ST_RDWAIT;
              end else begin
                out_v_nxt    = 1'b1;
                out_rv_nxt   = 1'b0;
                out_idx_nxt  = '0;
                out_dist_nxt = '0;
              end
            end
            KIND_CLEAR: cnt_nxt = '0;
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (new_lt) begin
          // tail entry of a full list falls off instead of moving
          if (rda_r != slot_r) begin
            we    = 1'b1;
            wdata = rdata_r;
          end
          slot_nxt = rda_r;
          if (rda_r == '0) begin
            state_nxt = ST_FINAL;
          end else begin
            re      = 1'b1;
            raddr   = rda_r - 1'b1;
            rda_nxt = raddr;
          end
        end else begin
          we        = rda_r != slot_r;
          state_nxt = ST_IDLE;
        end
      end
      ST_FINAL: begin
        we        = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_RDWAIT: begin
        out_v_nxt    = 1'b1;
        out_rv_nxt   = 1'b1;
        out_dist_nxt = rdata_r[EW-1:IDX_W];
        out_idx_nxt  = rdata_r[IDX_W-1:0];
        state_nxt    = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r     <= slot_nxt;
    rda_r      <= rda_nxt;
    new_r      <= new_nxt;
    out_rv_r   <= out_rv_nxt;
    out_idx_r  <= out_idx_nxt;
    out_dist_r <= out_dist_nxt;
  end

  assign out_ch.valid          = out_v_r;
  assign out_ch.rank_valid     = out_rv_r;
  assign out_ch.found_index    = out_idx_r;
  assign out_ch.found_distance = out_dist_r;

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= K_CNT)
    else $error("list count above TOP_K");
  assert property (@(posedge clk) disable iff (!rst_n)
    pop && head_cmd.kind == KIND_CLEAR |=> cnt_r == '0)
    else $error("clear did not empty the list");
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> rda_r <= slot_r)
    else $error("scan address passed insert slot");
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RDWAIT |-> !out_v_r || out_ch.ready)
    else $error("read data would overwrite a pending result");

endmodule

>>> design/pq_symmetric_distance_topk.sv
// A rank read passes the front-end stage register, command queue, list-memory read and output
// register (a rank beyond the list skips the read); front end takes one beat per cycle while
// the queue has room. List engine: clear and insert into empty list end at pop, read waits in
// ST_RDWAIT, other inserts scan from the tail in ST_SCAN; one write and one read list port.
// Reset clears the list count, query registers and queues; table banks keep contents.
module pq_symmetric_distance_topk import pqsd_pkg::*; #(
  parameter int TOP_K         = TOP_K_DEF,
  parameter int CODEBOOK_SIZE = CODEBOOK_DEF,
  parameter int SUBSPACES     = SUBSPACES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  pqsd_in_if.sink              in_ch,
  pqsd_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CODE_W-1:0]    cfg_wdata
);

  logic       push, pop, head_v;
  cmd_t       push_cmd, head_cmd;
  fifo_stat_t fifo_stat;

  pqsd_front #(
    .CODEBOOK_SIZE (CODEBOOK_SIZE),
    .SUBSPACES     (SUBSPACES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .fifo_stat (fifo_stat),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  pqsd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_v   (head_v),
    .head_cmd (head_cmd),
    .stat     (fifo_stat)
  );

  pqsd_back #(
    .TOP_K (TOP_K)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head_v   (head_v),
    .head_cmd (head_cmd),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule

>>> sim/tb_top.sv
// tb_top: self-checking bench for pq_symmetric_distance_topk (table loads, scans, rank reads).
// Depends on pqsd_pkg, pqsd_in_if, pqsd_out_if and the block itself.
`timescale 1ns / 100ps
module tb_top import pqsd_pkg::*;;

  localparam int K_KEEP      = TOP_K_DEF;
  localparam int SUBS        = SUBSPACES_DEF;
  localparam int CBK         = CODEBOOK_DEF;
  localparam int DRAIN_WAIT  = 1000;  // worst list insert times queue depth, with margin
  localparam int STALL_LIMIT = 5000;
  localparam int RAND_ITEMS  = 840;   // table preloads roughly double the beat count
  localparam int PHASES      = 6;

  localparam logic [CFG_IDX_W-1:0] REG_QUERY_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_QUERY_B = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_QUERY_C = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_QUERY_D = 2'd3;

  typedef struct {
    kind_t                        kind;
    logic [1:0]                   sub;
    logic [CODE_W-1:0]            row;
    logic [CODE_W-1:0]            col;
    logic [DIST_W-1:0]            val;
    logic [IDX_W-1:0]             idx;
    logic [3:0][CODE_W-1:0]       codes;
    logic [RANK_W-1:0]            rank;
    bit                           typed;  // expected read typed in, not predicted
  } beat_t;

  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] idx;
    logic [SUM_W-1:0] dsum;
  } rank_rsp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CODE_W-1:0] cfg_wdata = '0;

  pqsd_in_if  in_ch ();
  pqsd_out_if out_ch ();

  pq_symmetric_distance_topk dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  // shadow of the block
  logic [DIST_W-1:0] dist_tbl [SUBS][CBK][CBK];
  bit                tbl_loaded [SUBS][CBK][CBK];
  logic [CODE_W-1:0] query [4];
  logic [SUM_W-1:0]  kept_dist [K_KEEP];
  logic [IDX_W-1:0]  kept_idx [K_KEEP];
  int                kept_cnt;
  rank_rsp_t         pending_reads [$];

  int mismatches, reads_seen, items_scanned, table_loads, clears, in_beats, out_beats;

  function automatic bit pair_lt(logic [SUM_W-1:0] d1, logic [IDX_W-1:0] i1,
                                 logic [SUM_W-1:0] d2, logic [IDX_W-1:0] i2);
    return d1 < d2 || (d1 == d2 && i1 < i2);
  endfunction

  function automatic logic [SUM_W-1:0] scan_dist(logic [3:0][CODE_W-1:0] codes);
    logic [SUM_W-1:0] d;
    logic [CODE_W-1:0] hi, lo;
    d = '0;
    for (int s = 0; s < SUBS; s++) begin
      if (query[s] != codes[s]) begin
        hi = query[s] > codes[s] ? query[s] : codes[s];
        lo = query[s] > codes[s] ? codes[s] : query[s];
        d = d + SUM_W'(dist_tbl[s][hi][lo]);
      end
    end
    return d;
  endfunction

  function automatic void list_add(logic [SUM_W-1:0] d, logic [IDX_W-1:0] ix);
    int p, k;
    p = 0;
    while (p < kept_cnt && !pair_lt(d, ix, kept_dist[p], kept_idx[p])) p++;
    if (p >= K_KEEP) return;
    k = kept_cnt < K_KEEP ? kept_cnt : K_KEEP - 1;
    while (k > p) begin
      kept_dist[k] = kept_dist[k-1];
      kept_idx[k]  = kept_idx[k-1];
      k--;
    end
    kept_dist[p] = d;
    kept_idx[p]  = ix;
    if (kept_cnt < K_KEEP) kept_cnt++;
  endfunction

  // update shadow state for an accepted beat, queue the expected read-out
  function automatic void track_beat(beat_t b);
    logic [CODE_W-1:0] hi, lo;
    rank_rsp_t r;
    case (b.kind)
      KIND_WRITE: begin
        hi = b.row > b.col ? b.row : b.col;
        lo = b.row > b.col ? b.col : b.row;
        dist_tbl[b.sub][hi][lo] = b.val;
        tbl_loaded[b.sub][hi][lo] = 1'b1;
        table_loads++;
      end
      KIND_ITEM: begin
        list_add(scan_dist(b.codes), b.idx);
        items_scanned++;
      end
      KIND_READ: begin
        r = '0;
        if (!b.typed && b.rank < kept_cnt) begin
          r.hit  = 1'b1;
          r.idx  = kept_idx[b.rank];
          r.dsum = kept_dist[b.rank];
        end
        pending_reads = {pending_reads, r};
      end
      default: begin
        kept_cnt = 0;
        clears++;
      end
    endcase
  endfunction

  function automatic beat_t noise_beat(kind_t k);
    beat_t b;
    b.kind  = k;
    b.sub   = 2'($urandom);
    b.row   = 8'($urandom);
    b.col   = 8'($urandom);
    b.val   = 16'($urandom);
    b.idx   = 20'($urandom);
    b.codes = 32'($urandom);
    b.rank  = 7'($urandom);
    b.typed = 1'b0;
    return b;
  endfunction

  function automatic beat_t tw(int s, int r, int c, int v);
    beat_t b;
    b = noise_beat(KIND_WRITE);
    b.sub = 2'(s); b.row = 8'(r); b.col = 8'(c); b.val = 16'(v);
    return b;
  endfunction

  function automatic beat_t ti(int ix, int a, int bb, int c, int d);
    beat_t b;
    b = noise_beat(KIND_ITEM);
    b.idx = 20'(ix); b.codes = {8'(d), 8'(c), 8'(bb), 8'(a)};
    return b;
  endfunction

  function automatic beat_t tr(int rk, bit zero);
    beat_t b;
    b = noise_beat(KIND_READ);
    b.rank = 7'(rk); b.typed = zero;
    return b;
  endfunction

  int burst_left;

  task automatic push_beat(beat_t b);
    in_ch.valid       <= 1'b1;
    in_ch.kind        <= b.kind;
    in_ch.table_sub   <= b.sub;
    in_ch.table_row   <= b.row;
    in_ch.table_col   <= b.col;
    in_ch.table_value <= b.val;
    in_ch.entry_index <= b.idx;
    in_ch.code_a      <= b.codes[0];
    in_ch.code_b      <= b.codes[1];
    in_ch.code_c      <= b.codes[2];
    in_ch.code_d      <= b.codes[3];
    in_ch.read_rank   <= b.rank;
    do @(posedge clk); while (!in_ch.ready);
    track_beat(b);
    in_beats++;
    if (burst_left > 0) burst_left--;
    else begin
      burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60) : $urandom_range(0, 6);
      if ($urandom_range(0, 1)) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  endtask

  // scan beat: load any table entry it would read that is still unloaded
  task automatic push_any(beat_t b);
    logic [CODE_W-1:0] hi, lo;
    if (b.kind == KIND_ITEM) begin
      for (int s = 0; s < SUBS; s++) begin
        hi = query[s] > b.codes[s] ? query[s] : b.codes[s];
        lo = query[s] > b.codes[s] ? b.codes[s] : query[s];
        if (hi != lo && !tbl_loaded[s][hi][lo]) begin
          if ($urandom_range(0, 1))
            push_beat(tw(s, hi, lo, $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom));
          else
            push_beat(tw(s, lo, hi, $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom));
        end
      end
    end
    push_beat(b);
  endtask

  task automatic set_query(logic [CODE_W-1:0] qa, logic [CODE_W-1:0] qb,
                           logic [CODE_W-1:0] qc, logic [CODE_W-1:0] qd);
    logic [CODE_W-1:0] v [4];
    logic [CFG_IDX_W-1:0] regs [4];
    v = '{qa, qb, qc, qd};
    regs = '{REG_QUERY_A, REG_QUERY_B, REG_QUERY_C, REG_QUERY_D};
    in_ch.valid <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= regs[i];
      cfg_wdata <= v[i];
      @(posedge clk);
      query[i] = v[i];
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [CODE_W-1:0] pick_code(int s);
    case ($urandom_range(0, 3))
      0: return query[s];
      1: return 8'($urandom_range(0, 7));
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic beat_t rand_beat();
    beat_t b;
    int sel;
    sel = $urandom_range(0, 999);
    if (sel < 560) begin
      b = noise_beat(KIND_ITEM);
      for (int s = 0; s < 4; s++) b.codes[s] = pick_code(s);
      if ($urandom_range(0, 2) == 0) b.idx = 20'($urandom_range(0, 15));
    end else if (sel < 820) begin
      b = noise_beat(KIND_READ);
      if ($urandom_range(0, 3) != 0) b.rank = 7'($urandom_range(0, K_KEEP - 1));
    end else if (sel < 995) begin
      b = noise_beat(KIND_WRITE);
      if ($urandom_range(0, 1)) b.val = 16'($urandom_range(0, 3));
    end else
      b = noise_beat(KIND_CLEAR);
    return b;
  endfunction

  // result checker
  always @(posedge clk) begin
    rank_rsp_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      out_beats++;
      reads_seen++;
      if (pending_reads.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected read-out beat: hit=%0d idx=%0h dist=%0h",
                                       out_ch.rank_valid, out_ch.found_index,
                                       out_ch.found_distance);
      end else begin
        want = pending_reads.pop_front();
        if (out_ch.rank_valid !== want.hit || out_ch.found_index !== want.idx ||
            out_ch.found_distance !== want.dsum) begin
          mismatches++;
          if (mismatches <= 10)
            $display("read-out mismatch: exp hit=%0d idx=%0h dist=%0h, got hit=%0d idx=%0h dist=%0h",
                     want.hit, want.idx, want.dsum, out_ch.rank_valid,
                     out_ch.found_index, out_ch.found_distance);
        end
      end
    end
  end

  // receiver stall pattern, cycling through four ready styles
  int rx_cyc = 0;
  always @(posedge clk) begin
    rx_cyc <= rx_cyc + 1;
    case ((rx_cyc / 97) % 4)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= 1'($urandom);
      2: out_ch.ready <= (rx_cyc % 16) < 3;
      default: out_ch.ready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we || !rst_n)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
      $display("pq_symmetric_distance_topk regression: fail");
      $finish;
    end
  end

  beat_t directed [$];

  initial begin
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_CLEAR;
    in_ch.table_sub = '0;
    in_ch.table_row = '0;
    in_ch.table_col = '0;
    in_ch.table_value = '0;
    in_ch.entry_index = '0;
    in_ch.code_a = '0;
    in_ch.code_b = '0;
    in_ch.code_c = '0;
    in_ch.code_d = '0;
    in_ch.read_rank = '0;
    kept_cnt = 0;
    burst_left = 0;
    for (int i = 0; i < 4; i++) query[i] = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty list reads, swapped and equal-code writes, ties, repeats, clear
    directed = '{tr(0, 1), tr(127, 1),
                 tw(0, 0, 255, 16'hffff), tw(1, 255, 0, 0), tw(2, 0, 0, 16'h1234),
                 tw(3, 0, 128, 1), tw(2, 255, 0, 16'hffff), tw(3, 255, 0, 16'hffff),
                 ti(20'hfffff, 255, 255, 0, 128), ti(0, 0, 0, 0, 0), ti(0, 0, 0, 0, 0),
                 ti(5, 255, 0, 0, 0), ti(4, 255, 0, 0, 0), ti(7, 255, 255, 255, 255),
                 tr(0, 0), tr(1, 0), tr(2, 0), tr(3, 0), tr(4, 0), tr(5, 0), tr(6, 0),
                 noise_beat(KIND_CLEAR), tr(0, 1), ti(9, 0, 0, 0, 128), tr(0, 0)};
    foreach (directed[i]) push_any(directed[i]);

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: set_query(8'hff, 8'hff, 8'hff, 8'hff);
        1: set_query(8'h00, 8'hff, 8'h00, 8'hff);
        3: set_query(8'h00, 8'h00, 8'h00, 8'h00);
        default: set_query(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      endcase
      for (int n = 0; n < RAND_ITEMS / PHASES; n++) push_any(rand_beat());
    end
    in_ch.valid <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("covered %0d input beats: %0d table loads, %0d scans, %0d clears, %0d rank reads",
             in_beats, table_loads, items_scanned, clears, reads_seen);
    $display("query settings: reset, all-max, mixed extremes, all-zero and random; %0d mismatches",
             mismatches);
    if (mismatches == 0) $display("pq_symmetric_distance_topk regression: pass");
    else $display("pq_symmetric_distance_topk regression: fail");
    $finish;
  end

endmodule

>>> filelist.f
design/pqsd_pkg.sv
design/pqsd_in_if.sv
design/pqsd_out_if.sv
design/pqsd_front.sv
design/pqsd_fifo.sv
design/pqsd_back.sv
design/pq_symmetric_distance_topk.sv
sim/tb_top.sv
